/* hdl/fsc_pkg.sv */
package fsc_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
   localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

   // Format codes.
   localparam logic [4:0] FMT_UNKNOWN = 5'd0;
   localparam logic [4:0] FMT_PNG     = 5'd1;
   localparam logic [4:0] FMT_JPEG    = 5'd2;
   localparam logic [4:0] FMT_GIF     = 5'd3;
   localparam logic [4:0] FMT_BMP     = 5'd4;
   localparam logic [4:0] FMT_DDS     = 5'd5;
   localparam logic [4:0] FMT_KTX2    = 5'd6;
   localparam logic [4:0] FMT_KTX     = 5'd7;
   localparam logic [4:0] FMT_WAV     = 5'd8;
   localparam logic [4:0] FMT_RIFF    = 5'd9;
   localparam logic [4:0] FMT_OGG     = 5'd10;
   localparam logic [4:0] FMT_FLAC    = 5'd11;
   localparam logic [4:0] FMT_ID3     = 5'd12;
   localparam logic [4:0] FMT_ZIP     = 5'd13;
   localparam logic [4:0] FMT_GZIP    = 5'd14;
   localparam logic [4:0] FMT_BZIP2   = 5'd15;
   localparam logic [4:0] FMT_XZ      = 5'd16;
   localparam logic [4:0] FMT_ZSTD    = 5'd17;
   localparam logic [4:0] FMT_7Z      = 5'd18;
   localparam logic [4:0] FMT_ZLIB    = 5'd19;
   localparam logic [4:0] FMT_LUA     = 5'd20;
   localparam logic [4:0] FMT_XML     = 5'd21;

   // Family codes.
   localparam logic [2:0] FAM_NONE        = 3'd0;
   localparam logic [2:0] FAM_TEXTURE     = 3'd1;
   localparam logic [2:0] FAM_AUDIO       = 3'd2;
   localparam logic [2:0] FAM_CONTAINER   = 3'd3;
   localparam logic [2:0] FAM_ARCHIVE     = 3'd4;
   localparam logic [2:0] FAM_COMPRESSION = 3'd5;
   localparam logic [2:0] FAM_SCRIPT      = 3'd6;
   localparam logic [2:0] FAM_DOCUMENT    = 3'd7;

   typedef logic [HEADER_BYTES-1:0][7:0] fsc_header_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       file_start;
      logic       file_end;
   } fsc_req_type;

   typedef struct packed {
      logic [4:0] format_code;
      logic [2:0] family_code;
      logic       recognized;
   } fsc_rsp_type;

endpackage

/* hdl/fsc_classifier.sv */
module fsc_classifier
   import fsc_pkg::*;
(
   input  fsc_header_type   header,
   input  logic [CNT_W-1:0] bytes_seen,
   output fsc_rsp_type      result
);

   logic       have2, have3, have4, have5, have6, have8, have12;
   logic [7:0] cmf, flg;
   logic [8:0] zl_sum;
   logic [5:0] zl_fold;
   logic       zl_ok;
   logic [4:0] fmt;
   logic [2:0] fam;

   assign have2  = bytes_seen >= CNT_W'(2);
   assign have3  = bytes_seen >= CNT_W'(3);
   assign have4  = bytes_seen >= CNT_W'(4);
   assign have5  = bytes_seen >= CNT_W'(5);
   assign have6  = bytes_seen >= CNT_W'(6);
   assign have8  = bytes_seen >= CNT_W'(8);
   assign have12 = bytes_seen >= CNT_W'(12);

   // With CMF = 16*h + 8 and 256 = 8 (mod 31), CMF*256 + FLG is congruent
   // to 4*h + 2 + FLG. The sum is then folded once since 32 = 1 (mod 31).
   assign cmf     = header[0];
   assign flg     = header[1];
   assign zl_sum  = {4'b0000, cmf[6:4], 2'b10} + {1'b0, flg};
   assign zl_fold = {2'b00, zl_sum[8:5]} + {1'b0, zl_sum[4:0]};
   assign zl_ok   = have2 && (cmf[3:0] == 4'h8) && !cmf[7] &&
                    ((zl_fold == 6'd0) || (zl_fold == 6'd31));

   always_comb begin
      fmt = FMT_UNKNOWN;
      fam = FAM_NONE;
      if (have8 && header[0] == 8'h89 && header[1] == 8'h50 && header[2] == 8'h4e &&
          header[3] == 8'h47 && header[4] == 8'h0d && header[5] == 8'h0a &&
          header[6] == 8'h1a && header[7] == 8'h0a) begin
         fmt = FMT_PNG;  fam = FAM_TEXTURE;
      end else if (have3 && header[0] == 8'hff && header[1] == 8'hd8 &&
                   header[2] == 8'hff) begin
         fmt = FMT_JPEG; fam = FAM_TEXTURE;
      end else if (have6 && header[0] == 8'h47 && header[1] == 8'h49 &&
                   header[2] == 8'h46 && header[3] == 8'h38 &&
                   (header[4] == 8'h37 || header[4] == 8'h39) &&
                   header[5] == 8'h61) begin
         fmt = FMT_GIF;  fam = FAM_TEXTURE;
      end else if (have2 && header[0] == 8'h42 && header[1] == 8'h4d) begin
         fmt = FMT_BMP;  fam = FAM_TEXTURE;
      end else if (have4 && header[0] == 8'h44 && header[1] == 8'h44 &&
                   header[2] == 8'h53 && header[3] == 8'h20) begin
         fmt = FMT_DDS;  fam = FAM_TEXTURE;
      end else if (have12 && header[0] == 8'hab && header[1] == 8'h4b &&
                   header[2] == 8'h54 && header[3] == 8'h58 && header[4] == 8'h20 &&
                   ((header[5] == 8'h32 && header[6] == 8'h30) ||
                    (header[5] == 8'h31 && header[6] == 8'h31)) &&
                   header[7] == 8'hbb && header[8] == 8'h0d && header[9] == 8'h0a &&
                   header[10] == 8'h1a && header[11] == 8'h0a) begin
         fmt = (header[5] == 8'h32) ? FMT_KTX2 : FMT_KTX;
         fam = FAM_TEXTURE;
      end else if (have12 && header[0] == 8'h52 && header[1] == 8'h49 &&
                   header[2] == 8'h46 && header[3] == 8'h46) begin
         if (header[8] == 8'h57 && header[9] == 8'h41 && header[10] == 8'h56 &&
             header[11] == 8'h45) begin
            fmt = FMT_WAV;  fam = FAM_AUDIO;
         end else begin
            fmt = FMT_RIFF; fam = FAM_CONTAINER;
         end
      end else if (have4 && header[0] == 8'h4f && header[1] == 8'h67 &&
                   header[2] == 8'h67 && header[3] == 8'h53) begin
         fmt = FMT_OGG;  fam = FAM_AUDIO;
      end else if (have4 && header[0] == 8'h66 && header[1] == 8'h4c &&
                   header[2] == 8'h61 && header[3] == 8'h43) begin
         fmt = FMT_FLAC; fam = FAM_AUDIO;
      end else if (have3 && header[0] == 8'h49 && header[1] == 8'h44 &&
                   header[2] == 8'h33) begin
         fmt = FMT_ID3;  fam = FAM_AUDIO;
      end else if (have4 && header[0] == 8'h50 && header[1] == 8'h4b &&
                   ((header[2] == 8'h03 && header[3] == 8'h04) ||
                    (header[2] == 8'h05 && header[3] == 8'h06))) begin
         fmt = FMT_ZIP;  fam = FAM_ARCHIVE;
      end else if (have2 && header[0] == 8'h1f && header[1] == 8'h8b) begin
         fmt = FMT_GZIP; fam = FAM_COMPRESSION;
      end else if (have3 && header[0] == 8'h42 && header[1] == 8'h5a &&
                   header[2] == 8'h68) begin
         fmt = FMT_BZIP2; fam = FAM_COMPRESSION;
      end else if (have6 && header[0] == 8'hfd && header[1] == 8'h37 &&
                   header[2] == 8'h7a && header[3] == 8'h58 && header[4] == 8'h5a &&
                   header[5] == 8'h00) begin
         fmt = FMT_XZ;   fam = FAM_COMPRESSION;
      end else if (have4 && header[0] == 8'h28 && header[1] == 8'hb5 &&
                   header[2] == 8'h2f && header[3] == 8'hfd) begin
         fmt = FMT_ZSTD; fam = FAM_COMPRESSION;
      end else if (have6 && header[0] == 8'h37 && header[1] == 8'h7a &&
                   header[2] == 8'hbc && header[3] == 8'haf && header[4] == 8'h27 &&
                   header[5] == 8'h1c) begin
         fmt = FMT_7Z;   fam = FAM_ARCHIVE;
      end else if (zl_ok) begin
         fmt = FMT_ZLIB; fam = FAM_COMPRESSION;
      end else if (have4 && header[0] == 8'h1b && header[1] == 8'h4c &&
                   header[2] == 8'h75 && header[3] == 8'h61) begin
         fmt = FMT_LUA;  fam = FAM_SCRIPT;
      end else if (have5 && header[0] == 8'h3c && header[1] == 8'h3f &&
                   header[2] == 8'h78 && header[3] == 8'h6d && header[4] == 8'h6c) begin
         fmt = FMT_XML;  fam = FAM_DOCUMENT;
      end
   end

   assign result.format_code = fmt;
   assign result.family_code = fam;
   assign result.recognized  = (fmt != FMT_UNKNOWN);

endmodule

/* hdl/file_signature_classifier.sv */
// The transaction that completes the header (twelfth byte or file end) sets the
// pending flag; the result and rsp_valid are then registered once the output is free.
// Throughput: one request transaction per cycle; the input stalls only while a
// finished classification waits behind a stalled, full output register.
// Reset clears the byte count, the decided flag and both valid flags; the
// header bytes themselves are not cleared since the count gates every compare.
module file_signature_classifier
   import fsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fsc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fsc_rsp_type rsp_data
);

   fsc_header_type   header_ff;
   logic [CNT_W-1:0] count_ff, count_in, count_base;
   logic             decided_ff, decided_in, decided_base;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fsc_rsp_type      rsp_ff, class_result;
   logic             req_fire, out_free, store_byte, decide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   // A new file restarts the header before its own byte is taken.
   assign count_base   = req_data.file_start ? '0 : count_ff;
   assign decided_base = req_data.file_start ? 1'b0 : decided_ff;
   assign store_byte   = !decided_base && req_data.byte_present &&
                         (count_base < CNT_W'(HEADER_BYTES));

   always_comb begin
      count_in   = count_ff;
      decided_in = decided_ff;
      decide     = 1'b0;
      if (req_fire) begin
         count_in   = store_byte ? count_base + CNT_W'(1) : count_base;
         decide     = !decided_base &&
                      ((count_in >= CNT_W'(HEADER_BYTES)) || req_data.file_end);
         decided_in = decided_base || decide;
      end
   end

   assign pend_in = req_fire ? decide : (pend_ff && !out_free);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         decided_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         decided_ff   <= decided_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && store_byte) begin
         header_ff[count_base[HDR_IDX_W-1:0]] <= req_data.data_byte;
      end
      if (pend_ff && out_free) begin
         rsp_ff <= class_result;
      end
   end

   fsc_classifier u_classifier (
      .header     (header_ff),
      .bytes_seen (count_ff),
      .result     (class_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pend_ff))
      else $error("Result became valid without a pending classification.");

   a_recognized_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.recognized == (rsp_data.format_code != FMT_UNKNOWN)))
      else $error("Recognized flag disagrees with format code.");

   a_decided_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && decided_ff && !req_data.file_start) |=> !pend_ff)
      else $error("A decided file produced another classification.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEADER_BYTES))
      else $error("Byte count exceeded the header size.");

endmodule
